>>> design/salsa_pkg.sv
package salsa_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int STEPS_PER_PASS = 4;
  localparam int PASSES = 2 * DOUBLE_ROUNDS;
  localparam int STAGES = PASSES * STEPS_PER_PASS;

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] in_w01;
    logic [63:0] in_w23;
    logic [63:0] in_w45;
    logic [63:0] in_w67;
    logic [63:0] in_w89;
    logic [63:0] in_w1011;
    logic [63:0] in_w1213;
    logic [63:0] in_w1415;
  } item_t;

  typedef struct packed {
    logic [63:0] out_w01;
    logic [63:0] out_w23;
    logic [63:0] out_w45;
    logic [63:0] out_w67;
    logic [63:0] out_w89;
    logic [63:0] out_w1011;
    logic [63:0] out_w1213;
    logic [63:0] out_w1415;
  } result_t;

  typedef struct packed {
    logic   kind;
    words_t w;
    words_t z;
  } stage_t;

  localparam logic KIND_SALSA20  = 1'b0;
  localparam logic KIND_HSALSA20 = 1'b1;

  // Column groups first, then row groups; diagonal element leads each group.
  localparam logic [3:0] QR_GROUPS [8][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11},
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  // Rotate left by 7, 9, 13 or 18 for phases 0..3.
  function automatic logic [31:0] rotl_phase(logic [31:0] v, logic [1:0] phase);
    logic [31:0] r;
    unique case (phase)
      2'd0: r = {v[24:0], v[31:25]};
      2'd1: r = {v[22:0], v[31:23]};
      2'd2: r = {v[18:0], v[31:19]};
      2'd3: r = {v[13:0], v[31:14]};
      default: r = v;
    endcase
    return r;
  endfunction

  // One add-rotate-xor step of all four quarter rounds of a pass.
  function automatic words_t qr_step(words_t z, logic row, logic [1:0] phase);
    words_t      r;
    logic [1:0]  gi;
    logic [2:0]  grp;
    logic [3:0]  src_a;
    logic [3:0]  src_b;
    logic [3:0]  dst;
    logic [31:0] s;
    r = z;
    for (int g = 0; g < 4; g++) begin
      gi    = 2'(g);
      grp   = {row, gi};
      src_a = QR_GROUPS[grp][phase];
      src_b = QR_GROUPS[grp][phase + 2'd3];
      dst   = QR_GROUPS[grp][phase + 2'd1];
      s     = z[src_a] + z[src_b];
      r[dst] = z[dst] ^ rotl_phase(s, phase);
    end
    return r;
  endfunction

endpackage

>>> design/salsa20_hsalsa20_core.sv
// Salsa20/20 core and HSalsa20 core in a fully unrolled pipeline. One block
// may be started in every cycle; busy is high only during reset. Each
// quarter-round step of every pass has its own register stage, and a final
// registered stage adds the input words or picks the HSalsa20 output words;
// results leave in start order. result_valid marks each
// result for exactly one cycle and cannot be held off, so the receiver must
// take every result beat as it appears.
module salsa20_hsalsa20_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  salsa_pkg::item_t   item,
  output logic               result_valid,
  output salsa_pkg::result_t result
);
  import salsa_pkg::*;

  stage_t           pipe [STAGES+1];
  logic [STAGES:0]  pipe_valid;
  words_t           in_words;

  assign busy = rst;

  always_comb begin
    in_words[0]  = item.in_w01[31:0];
    in_words[1]  = item.in_w01[63:32];
    in_words[2]  = item.in_w23[31:0];
    in_words[3]  = item.in_w23[63:32];
    in_words[4]  = item.in_w45[31:0];
    in_words[5]  = item.in_w45[63:32];
    in_words[6]  = item.in_w67[31:0];
    in_words[7]  = item.in_w67[63:32];
    in_words[8]  = item.in_w89[31:0];
    in_words[9]  = item.in_w89[63:32];
    in_words[10] = item.in_w1011[31:0];
    in_words[11] = item.in_w1011[63:32];
    in_words[12] = item.in_w1213[31:0];
    in_words[13] = item.in_w1213[63:32];
    in_words[14] = item.in_w1415[31:0];
    in_words[15] = item.in_w1415[63:32];
  end

  assign pipe_valid[0] = start & ~busy;
  assign pipe[0].kind  = item.kind;
  assign pipe[0].w     = in_words;
  assign pipe[0].z     = in_words;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [1:0] PHASE = 2'(s % STEPS_PER_PASS);
    localparam logic       ROW   = 1'((s / STEPS_PER_PASS) % 2);

    salsa_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .row       (ROW),
      .phase     (PHASE),
      .in_valid  (pipe_valid[s]),
      .in_data   (pipe[s]),
      .out_valid (pipe_valid[s+1]),
      .out_data  (pipe[s+1])
    );
  end

  salsa_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pipe_valid[STAGES]),
    .in_data      (pipe[STAGES]),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> design/salsa_stage.sv
module salsa_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              row,
  input  logic [1:0]        phase,
  input  logic              in_valid,
  input  salsa_pkg::stage_t in_data,
  output logic              out_valid,
  output salsa_pkg::stage_t out_data
);
  import salsa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data.kind <= in_data.kind;
    out_data.w    <= in_data.w;
    out_data.z    <= qr_step(in_data.z, row, phase);
  end

endmodule

>>> design/salsa_out.sv
module salsa_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  salsa_pkg::stage_t  in_data,
  output logic               result_valid,
  output salsa_pkg::result_t result
);
  import salsa_pkg::*;

  words_t  sum;
  result_t result_next;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sum[i] = in_data.z[i] + in_data.w[i];
    end
    unique case (in_data.kind)
      KIND_HSALSA20: begin
        result_next.out_w01   = {in_data.z[5],  in_data.z[0]};
        result_next.out_w23   = {in_data.z[15], in_data.z[10]};
        result_next.out_w45   = {in_data.z[7],  in_data.z[6]};
        result_next.out_w67   = {in_data.z[9],  in_data.z[8]};
        result_next.out_w89   = '0;
        result_next.out_w1011 = '0;
        result_next.out_w1213 = '0;
        result_next.out_w1415 = '0;
      end
      default: begin
        result_next.out_w01   = {sum[1],  sum[0]};
        result_next.out_w23   = {sum[3],  sum[2]};
        result_next.out_w45   = {sum[5],  sum[4]};
        result_next.out_w67   = {sum[7],  sum[6]};
        result_next.out_w89   = {sum[9],  sum[8]};
        result_next.out_w1011 = {sum[11], sum[10]};
        result_next.out_w1213 = {sum[13], sum[12]};
        result_next.out_w1415 = {sum[15], sum[14]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> tb/tb_salsa20_hsalsa20_core.sv
`timescale 1ns / 100ps

import salsa_pkg::*;

class block_scoreboard;
  result_t     pending_outputs[$];
  int          errors;
  logic [31:0] zs[16];

  function new();
    errors = 0;
  endfunction

  function logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void quarter(int a, int b, int c, int d);
    zs[b] = zs[b] ^ rotl(zs[a] + zs[d], 7);
    zs[c] = zs[c] ^ rotl(zs[b] + zs[a], 9);
    zs[d] = zs[d] ^ rotl(zs[c] + zs[b], 13);
    zs[a] = zs[a] ^ rotl(zs[d] + zs[c], 18);
  endfunction

  function result_t salsa_permute(item_t it);
    logic [63:0] packed_in[8];
    logic [31:0] ws[16];
    logic [63:0] outs[8];
    result_t     r;
    packed_in = '{it.in_w01, it.in_w23, it.in_w45, it.in_w67,
                  it.in_w89, it.in_w1011, it.in_w1213, it.in_w1415};
    for (int i = 0; i < 8; i++) begin
      ws[2*i]   = packed_in[i][31:0];
      ws[2*i+1] = packed_in[i][63:32];
    end
    zs = ws;
    for (int rnd = 0; rnd < DOUBLE_ROUNDS; rnd++) begin
      quarter(0, 4, 8, 12);
      quarter(5, 9, 13, 1);
      quarter(10, 14, 2, 6);
      quarter(15, 3, 7, 11);
      quarter(0, 1, 2, 3);
      quarter(5, 6, 7, 4);
      quarter(10, 11, 8, 9);
      quarter(15, 12, 13, 14);
    end
    if (it.kind == KIND_HSALSA20) begin
      outs = '{{zs[5], zs[0]}, {zs[15], zs[10]}, {zs[7], zs[6]}, {zs[9], zs[8]},
               64'd0, 64'd0, 64'd0, 64'd0};
    end else begin
      for (int i = 0; i < 8; i++)
        outs[i] = {zs[2*i+1] + ws[2*i+1], zs[2*i] + ws[2*i]};
    end
    r = {outs[0], outs[1], outs[2], outs[3], outs[4], outs[5], outs[6], outs[7]};
    return r;
  endfunction

  function void note_block(item_t it);
    pending_outputs.push_back(salsa_permute(it));
  endfunction

  function void check_result(result_t got);
    result_t     want;
    logic [63:0] e[8];
    logic [63:0] a[8];
    if (pending_outputs.size() == 0) begin
      $display("%0t: unexpected result beat, got %h", $time, got);
      errors++;
      return;
    end
    want = pending_outputs.pop_front();
    e = '{want.out_w01, want.out_w23, want.out_w45, want.out_w67,
          want.out_w89, want.out_w1011, want.out_w1213, want.out_w1415};
    a = '{got.out_w01, got.out_w23, got.out_w45, got.out_w67,
          got.out_w89, got.out_w1011, got.out_w1213, got.out_w1415};
    for (int i = 0; i < 8; i++) begin
      if (a[i] !== e[i]) begin
        $display("%0t: mismatch on result field %0d, expected %h, actual %h",
                 $time, i, e[i], a[i]);
        errors++;
      end
    end
  endfunction

  function int pending();
    return pending_outputs.size();
  endfunction
endclass

module tb_salsa20_hsalsa20_core;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BLOCKS = 1950;
  localparam int QUIET_TAIL = 300;
  localparam int DRAIN_CYCLES = 120;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    result_valid;
  result_t result;

  int              cycles = 0;
  block_scoreboard sb = new();

  salsa20_hsalsa20_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (start === 1'b1 && busy === 1'b0)
      sb.note_block(item);
    if (result_valid === 1'b1)
      sb.check_result(result);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t to_item(logic k, words_t w);
    item_t it;
    it.kind      = k;
    it.in_w01    = {w[1], w[0]};
    it.in_w23    = {w[3], w[2]};
    it.in_w45    = {w[5], w[4]};
    it.in_w67    = {w[7], w[6]};
    it.in_w89    = {w[9], w[8]};
    it.in_w1011  = {w[11], w[10]};
    it.in_w1213  = {w[13], w[12]};
    it.in_w1415  = {w[15], w[14]};
    return it;
  endfunction

  function automatic item_t rand_block();
    words_t w;
    logic   k;
    k = $urandom_range(0, 1) ? KIND_HSALSA20 : KIND_SALSA20;
    for (int i = 0; i < 16; i++)
      w[i] = rand_word();
    return to_item(k, w);
  endfunction

  // hold start low, with junk on the payload
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      item  = rand_block();
    end
  endtask

  task automatic send_block(item_t it);
    @(negedge clk);
    item  = it;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  initial begin
    words_t w;
    logic   k;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int kk = 0; kk < 2; kk++) begin
      k = kk[0] ? KIND_HSALSA20 : KIND_SALSA20;
      for (int pat = 0; pat < 7; pat++) begin
        for (int i = 0; i < 16; i++) begin
          case (pat)
            0: w[i] = 32'h0000_0000;
            1: w[i] = 32'hffff_ffff;
            2: w[i] = 32'h5555_5555;
            3: w[i] = 32'haaaa_aaaa;
            4: w[i] = 32'd1 << i;
            5: w[i] = 32'(i);
            default: w[i] = 32'h8000_0000;
          endcase
        end
        if (pat == 3)
          hold_off($urandom_range(1, 9));
        send_block(to_item(k, w));
      end
    end

    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      if (n < RANDOM_BLOCKS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 9));
      send_block(rand_block());
    end
    @(negedge clk);
    start = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
